/* rtl/mean_deviation_outlier_filter_macros.svh */
// assertion macros for the outlier filter checker
`ifndef MEAN_DEVIATION_OUTLIER_FILTER_MACROS_SVH
`define MEAN_DEVIATION_OUTLIER_FILTER_MACROS_SVH

// property that holds from an antecedent in the same cycle
`define MDOF_ASSERT_SAME(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// property that holds from an antecedent in the next cycle
`define MDOF_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/mdof_pkg.sv */
// shared types and constants of the outlier filter
`default_nettype none
package mdof_pkg;
	localparam int unsigned POINT_W = 128;
	localparam int unsigned Z_W = 32;
	localparam int unsigned SCALE_W = 16;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
	localparam int unsigned IN_DATA_W = 128;
	localparam int unsigned OUT_DATA_W = 128;
	localparam int unsigned OUT_USER_W = 2;

	// command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_PULL = 1'b1;

	// controller states
	typedef enum logic [8:0] {
		ST_LOAD = 9'b000000001,
		ST_DIV1 = 9'b000000010,
		ST_SCAN = 9'b000000100,
		ST_DIV2 = 9'b000001000,
		ST_MUL = 9'b000010000,
		ST_PULL = 9'b000100000,
		ST_RDWAIT = 9'b001000000,
		ST_OUT = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;
endpackage
`default_nettype wire

/* rtl/mean_deviation_outlier_filter.sv */
// top level of the mean absolute deviation outlier filter
`default_nettype none
// Points load one per cycle into a single-port store while the input is ready. A
// load with the last flag starts the computation: a bit-serial divider gives the
// mean, a memory scan sums the absolute deviations, a second division gives the
// deviation and a multiply scales it. A pull then walks the store one entry per
// cycle (each read is registered); its result is registered once a kept point is
// read, or as done once the store is walked, and a pull with no point left answers
// at once. The input waits while a result is pending. A pull during loading, or
// once the cloud is exhausted, answers done. The scale register is sampled when the
// cloud is finished.
module mean_deviation_outlier_filter #(
	parameter int unsigned POINT_CAPACITY = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [mdof_pkg::SCALE_W-1:0] cfg_wdata,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// pos_x, pos_y, pos_z, red, green, blue, alpha
	input wire logic [mdof_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// command
	input wire logic s_axis_tuser,
	input wire logic s_axis_tlast,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// out_x, out_y, out_z, out_red, out_green, out_blue, out_alpha
	output logic [mdof_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// point_valid, done_res
	output logic [mdof_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import mdof_pkg::*;

	localparam int unsigned AW = (POINT_CAPACITY > 1) ? $clog2(POINT_CAPACITY) : 1;
	localparam int unsigned CW = $clog2(POINT_CAPACITY + 1);
	localparam int unsigned SUM_W = Z_W + CW + 1;
	localparam int unsigned DSUM_W = SUM_W + 1;
	localparam int unsigned DIVC_W = $clog2(DSUM_W + 1);
	localparam logic [CW-1:0] CAP = CW'(POINT_CAPACITY);

	logic [POINT_W-1:0] mem [POINT_CAPACITY];
	logic [POINT_W-1:0] rd_data_q;
	logic [AW-1:0] rd_addr;
	logic rd_en;
	logic wr_en;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic signed [SUM_W-1:0] esum_q;
	logic [DSUM_W-1:0] dsum_q;
	logic signed [Z_W-1:0] mean_q;
	logic [SCALE_W-1:0] scale_q;
	logic [SCALE_W-1:0] scale_use_q;
	logic [DSUM_W-1:0] dev_q;
	logic signed [DSUM_W+SCALE_W:0] band_q;
	logic scan_vld_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;
	logic out_vld_q;

	// divider registers: restoring, one quotient bit per cycle
	logic [DSUM_W-1:0] dq_q;
	logic [CW:0] drem_q;
	logic [DIVC_W-1:0] dcnt_q;
	logic dneg_q;
	logic [CW+1:0] drem_sh;
	logic [CW+1:0] drem_sub;

	logic in_xfer;
	logic is_load;
	logic is_pull;
	logic signed [Z_W-1:0] rd_z;
	logic signed [Z_W:0] diff;
	logic [Z_W:0] adiff;
	logic signed [DSUM_W+SCALE_W+1:0] lo;
	logic signed [DSUM_W+SCALE_W+1:0] hi;
	logic keep;
	logic [DSUM_W-1:0] esum_abs;

	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign is_load = in_xfer && (s_axis_tuser == CMD_LOAD);
	assign is_pull = in_xfer && (s_axis_tuser == CMD_PULL);
	assign s_axis_tready = (state_q == ST_LOAD || state_q == ST_PULL || state_q == ST_DONE)
		&& !out_vld_q;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_user_q;

	// store port control
	assign wr_en = is_load && (state_q != ST_LOAD || count_q < CAP);
	always_comb begin
		rd_en = 1'b0;
		rd_addr = idx_q[AW-1:0];
		if (state_q == ST_SCAN && idx_q < count_q) begin
			rd_en = 1'b1;
		end else if ((state_q == ST_PULL && is_pull) || state_q == ST_RDWAIT) begin
			rd_en = idx_q < count_q;
		end
	end

	// point store, one port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[(state_q == ST_LOAD) ? count_q[AW-1:0] : '0] <= s_axis_tdata[POINT_W-1:0];
		end else if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_z = rd_data_q[95:64];
	assign diff = Z_W'(mean_q) - Z_W'(rd_z) + 33'sd0;
	assign adiff = diff[Z_W] ? (Z_W+1)'(-diff) : (Z_W+1)'(diff);
	assign lo = (DSUM_W+SCALE_W+2)'(mean_q) - (DSUM_W+SCALE_W+2)'(band_q);
	assign hi = (DSUM_W+SCALE_W+2)'(mean_q) + (DSUM_W+SCALE_W+2)'(band_q);
	assign keep = ((DSUM_W+SCALE_W+2)'(rd_z) >= lo) && ((DSUM_W+SCALE_W+2)'(rd_z) <= hi);
	assign esum_abs = esum_q[SUM_W-1] ? DSUM_W'(-esum_q) : DSUM_W'(esum_q);
	assign drem_sh = {drem_q, dq_q[DSUM_W-1]};
	assign drem_sub = drem_sh - (CW+2)'(count_q);

	// scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			scale_q <= cfg_wdata;
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			idx_q <= '0;
			esum_q <= '0;
			dsum_q <= '0;
			mean_q <= '0;
			scale_use_q <= '0;
			dev_q <= '0;
			band_q <= '0;
			scan_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
			out_data_q <= '0;
			out_user_q <= '0;
			dq_q <= '0;
			drem_q <= '0;
			dcnt_q <= '0;
			dneg_q <= 1'b0;
		end else begin
			if (out_vld_q && m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD, ST_PULL, ST_DONE: begin
					if (is_load) begin
						// loading, or a load that starts a new cloud
						if (state_q != ST_LOAD) begin
							count_q <= CW'(1);
							esum_q <= SUM_W'(signed'(s_axis_tdata[95:64]));
						end else if (count_q < CAP) begin
							count_q <= count_q + 1'b1;
							esum_q <= esum_q + SUM_W'(signed'(s_axis_tdata[95:64]));
						end
						if (s_axis_tlast) begin
							state_q <= ST_DIV1;
							scale_use_q <= scale_q;
							dcnt_q <= '0;
							drem_q <= '0;
							if (state_q != ST_LOAD) begin
								dq_q <= DSUM_W'(s_axis_tdata[95]
									? -signed'(s_axis_tdata[95:64]) + 33'sd0
									: signed'(s_axis_tdata[95:64]) + 33'sd0);
								dneg_q <= s_axis_tdata[95];
							end else begin
								dq_q <= esum_abs;
								dneg_q <= esum_q[SUM_W-1];
								if (count_q < CAP) begin
									dq_q <= DSUM_W'((esum_q + SUM_W'(signed'(s_axis_tdata[95:64])))
										< 0 ? -(esum_q + SUM_W'(signed'(s_axis_tdata[95:64])))
										: (esum_q + SUM_W'(signed'(s_axis_tdata[95:64]))));
									dneg_q <= (esum_q + SUM_W'(signed'(s_axis_tdata[95:64]))) < 0;
								end
							end
						end else begin
							state_q <= ST_LOAD;
						end
					end else if (is_pull) begin
						if (state_q == ST_PULL && idx_q < count_q) begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_RDWAIT;
						end else begin
							// no point left, or still loading: answer done
							if (state_q == ST_PULL) begin
								state_q <= ST_DONE;
							end
							out_vld_q <= 1'b1;
							out_data_q <= '0;
							out_user_q <= 2'b10;
						end
					end
				end
				ST_DIV1, ST_DIV2: begin
					// shift-subtract step
					if (drem_sub[CW+1]) begin
						drem_q <= drem_sh[CW:0];
						dq_q <= {dq_q[DSUM_W-2:0], 1'b0};
					end else begin
						drem_q <= drem_sub[CW:0];
						dq_q <= {dq_q[DSUM_W-2:0], 1'b1};
					end
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DIVC_W'(DSUM_W)) begin
						dcnt_q <= '0;
						if (state_q == ST_DIV1) begin
							mean_q <= dneg_q ? -Z_W'(dq_q) : Z_W'(dq_q);
							idx_q <= '0;
							dsum_q <= '0;
							scan_vld_q <= 1'b0;
							state_q <= ST_SCAN;
						end else begin
							dev_q <= dq_q;
							state_q <= ST_MUL;
						end
						drem_q <= drem_q;
						dq_q <= dq_q;
					end
				end
				ST_SCAN: begin
					// read each point, accumulate absolute deviation
					scan_vld_q <= rd_en;
					if (rd_en) begin
						idx_q <= idx_q + 1'b1;
					end
					if (scan_vld_q) begin
						dsum_q <= dsum_q + DSUM_W'(adiff);
					end
					if (!rd_en && !scan_vld_q) begin
						dq_q <= dsum_q;
						drem_q <= '0;
						dneg_q <= 1'b0;
						state_q <= ST_DIV2;
					end
				end
				ST_MUL: begin
					// mean deviation never exceeds the largest 32-bit distance
					band_q <= signed'({1'b0,
						(DSUM_W+SCALE_W)'(dev_q[Z_W-1:0] * scale_use_q) >> 8});
					idx_q <= '0;
					state_q <= ST_PULL;
				end
				ST_RDWAIT: begin
					// test the point just read
					if (keep) begin
						out_vld_q <= 1'b1;
						out_data_q <= rd_data_q;
						out_user_q <= 2'b01;
						state_q <= ST_PULL;
					end else if (idx_q < count_q) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						out_vld_q <= 1'b1;
						out_data_q <= '0;
						out_user_q <= 2'b10;
						state_q <= ST_DONE;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/mdof_checker.sv */
// port-level checker for the outlier filter, with its bind
`default_nettype none
`include "mean_deviation_outlier_filter_macros.svh"
module mdof_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [1:0] m_axis_tuser
);
	// a result is a point or done, never both
	`MDOF_ASSERT_SAME(a_one_kind, clk, arst_n, m_axis_tvalid, $onehot(m_axis_tuser))
	// no new item taken while a result waits
	`MDOF_ASSERT_SAME(a_no_overlap, clk, arst_n, m_axis_tvalid, !s_axis_tready)
	// a stalled result stays
	`MDOF_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tuser))
endmodule

bind mean_deviation_outlier_filter mdof_checker u_mdof_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tuser(m_axis_tuser)
);
`default_nettype wire
